// ===== hw/rtl/segint_pkg.sv =====
package segint_pkg;

  // Coordinate formats: inputs and offsets are 23-bit signed fixed point.
  localparam int CoordW   = 23;
  localparam int SumW     = CoordW + 1;
  localparam int DiffW    = SumW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int NumW     = ProdW + 1;
  localparam int FracBits = 8;
  localparam int CfgIdxW  = 3;

  localparam logic [SumW-1:0] FracMask = SumW'((64'd1 << FracBits) - 64'd1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgOwnX   = 3'd0,
    CfgOwnY   = 3'd1,
    CfgOtherX = 3'd2,
    CfgOtherY = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] own_x;
    logic signed [CoordW-1:0] own_y;
    logic signed [CoordW-1:0] other_x;
    logic signed [CoordW-1:0] other_y;
  } offsets_t;

  // Everything the back half needs, as produced by the front half.
  typedef struct packed {
    logic signed [DiffW-1:0] ax;
    logic signed [DiffW-1:0] ay;
    logic signed [DiffW-1:0] bx;
    logic signed [DiffW-1:0] by;
    logic signed [DiffW-1:0] cx;
    logic signed [DiffW-1:0] cy;
    logic signed [SumW-1:0]  ix0;
    logic signed [SumW-1:0]  ix1;
    logic signed [SumW-1:0]  ix2;
    logic signed [SumW-1:0]  ix3;
    logic signed [SumW-1:0]  iy0;
    logic signed [SumW-1:0]  iy1;
    logic signed [SumW-1:0]  iy2;
    logic signed [SumW-1:0]  iy3;
  } front_t;

  // Integer part, truncated toward zero.
  function automatic logic signed [SumW-1:0] int_part(logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] sh;
    logic                   frac_nz;
    sh      = v >>> FracBits;
    frac_nz = |(v & FracMask);
    return sh + SumW'(v[SumW-1] && frac_nz);
  endfunction

endpackage

// ===== hw/rtl/segment_pair_intersect_test_unit.sv =====
// Segment pair intersection test.
// Load the two shape positions through the configuration channel
// (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i): index 0 and 1 are the
// first shape's X and Y, index 2 and 3 the second shape's; other indexes are
// ignored. cfg_ready_o is always high. Write only while no pair is in flight.
// A pair of segments is taken on each clock edge with start_i high and
// busy_o low. busy_o is high during reset and in the first cycle after it;
// the block then takes one pair every cycle.
// The answer appears on hit_o, marked by done_o for exactly one cycle;
// answers leave in the order pairs entered. The pipeline has five register
// stages: endpoint offsets, edge vectors and integer parts, box tests with
// six 25x25 multipliers, the numerator and denominator subtractions, and the
// final range tests.
// The receiver cannot stall, so nothing ever backs up. Reset clears the
// offsets to zero and drops every pair in flight.
module segment_pair_intersect_test_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [segint_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [segint_pkg::CoordW-1:0]         cfg_data_i,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [segint_pkg::CoordW-1:0]  own_start_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  own_start_y_i,
  input  logic signed [segint_pkg::CoordW-1:0]  own_end_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  own_end_y_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_start_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_start_y_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_end_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_end_y_i,
  output logic                                  done_o,
  output logic                                  hit_o
);
  import segint_pkg::*;

  offsets_t offsets;
  front_t   front;
  logic     front_valid;
  logic     accept;

  assign accept = start_i && !busy_o;

  segint_hold_check u_hold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_o  (busy_o)
  );

  segint_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .offsets_o   (offsets)
  );

  segint_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (accept),
    .own_start_x_i   (own_start_x_i),
    .own_start_y_i   (own_start_y_i),
    .own_end_x_i     (own_end_x_i),
    .own_end_y_i     (own_end_y_i),
    .other_start_x_i (other_start_x_i),
    .other_start_y_i (other_start_y_i),
    .other_end_x_i   (other_end_x_i),
    .other_end_y_i   (other_end_y_i),
    .offsets_i       (offsets),
    .valid_o         (front_valid),
    .front_o         (front)
  );

  segint_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .front_i (front),
    .valid_o (done_o),
    .hit_o   (hit_o)
  );

endmodule

// ===== hw/rtl/segint_cfg_regs.sv =====
module segint_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [segint_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [segint_pkg::CoordW-1:0]       cfg_data_i,
  output logic                                cfg_ready_o,
  output segint_pkg::offsets_t                offsets_o
);
  import segint_pkg::*;

  offsets_t offsets_d, offsets_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    offsets_d = offsets_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgOwnX:   offsets_d.own_x   = cfg_data_i;
        CfgOwnY:   offsets_d.own_y   = cfg_data_i;
        CfgOtherX: offsets_d.other_x = cfg_data_i;
        CfgOtherY: offsets_d.other_y = cfg_data_i;
        default:   offsets_d = offsets_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q <= '0;
    end else begin
      offsets_q <= offsets_d;
    end
  end

  assign offsets_o = offsets_q;

endmodule

// ===== hw/rtl/segint_front.sv =====
module segint_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [segint_pkg::CoordW-1:0]  own_start_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  own_start_y_i,
  input  logic signed [segint_pkg::CoordW-1:0]  own_end_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  own_end_y_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_start_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_start_y_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_end_x_i,
  input  logic signed [segint_pkg::CoordW-1:0]  other_end_y_i,
  input  segint_pkg::offsets_t                  offsets_i,
  output logic                                  valid_o,
  output segint_pkg::front_t                    front_o
);
  import segint_pkg::*;

  logic signed [SumW-1:0] x0_d, y0_d, x1_d, y1_d, x2_d, y2_d, x3_d, y3_d;
  logic signed [SumW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic                   v1_q, v2_q;
  front_t                 front_d, front_q;

  // Stage 1: place each endpoint by its shape's offset.
  assign x0_d = SumW'(own_start_x_i)   + SumW'(offsets_i.own_x);
  assign y0_d = SumW'(own_start_y_i)   + SumW'(offsets_i.own_y);
  assign x1_d = SumW'(own_end_x_i)     + SumW'(offsets_i.own_x);
  assign y1_d = SumW'(own_end_y_i)     + SumW'(offsets_i.own_y);
  assign x2_d = SumW'(other_start_x_i) + SumW'(offsets_i.other_x);
  assign y2_d = SumW'(other_start_y_i) + SumW'(offsets_i.other_y);
  assign x3_d = SumW'(other_end_x_i)   + SumW'(offsets_i.other_x);
  assign y3_d = SumW'(other_end_y_i)   + SumW'(offsets_i.other_y);

  always_ff @(posedge clk_i) begin
    x0_q <= x0_d;
    y0_q <= y0_d;
    x1_q <= x1_d;
    y1_q <= y1_d;
    x2_q <= x2_d;
    y2_q <= y2_d;
    x3_q <= x3_d;
    y3_q <= y3_d;
  end

  // Stage 2: edge vectors and truncated integer parts.
  always_comb begin
    front_d.ax  = DiffW'(x1_q) - DiffW'(x0_q);
    front_d.ay  = DiffW'(y1_q) - DiffW'(y0_q);
    front_d.bx  = DiffW'(x2_q) - DiffW'(x3_q);
    front_d.by  = DiffW'(y2_q) - DiffW'(y3_q);
    front_d.cx  = DiffW'(x0_q) - DiffW'(x2_q);
    front_d.cy  = DiffW'(y0_q) - DiffW'(y2_q);
    front_d.ix0 = int_part(x0_q);
    front_d.ix1 = int_part(x1_q);
    front_d.ix2 = int_part(x2_q);
    front_d.ix3 = int_part(x3_q);
    front_d.iy0 = int_part(y0_q);
    front_d.iy1 = int_part(y1_q);
    front_d.iy2 = int_part(y2_q);
    front_d.iy3 = int_part(y3_q);
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign front_o = front_q;

endmodule

// ===== hw/rtl/segint_back.sv =====
module segint_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  segint_pkg::front_t front_i,
  output logic               valid_o,
  output logic               hit_o
);
  import segint_pkg::*;

  logic                    box_ok_d, box_ok3_q, box_ok4_q;
  logic signed [ProdW-1:0] p_bycx_q, p_bxcy_q, p_aybx_q, p_axby_q, p_axcy_q, p_aycx_q;
  logic signed [NumW-1:0]  d_d, e_d, f_d, d_q, e_q, f_q;
  logic                    v3_q, v4_q, v5_q;
  logic                    hit_d, hit_q;

  // Stage 3: bounding-box rejects alongside the six cross products.
  always_comb begin
    logic signed [SumW-1:0] lo, hi;
    logic                   x_ok, y_ok;
    logic                   bx_pos, by_pos;
    bx_pos = !front_i.bx[DiffW-1] && (front_i.bx != '0);
    by_pos = !front_i.by[DiffW-1] && (front_i.by != '0);

    if (front_i.ax[DiffW-1]) begin
      lo = front_i.ix1;
      hi = front_i.ix0;
    end else begin
      lo = front_i.ix0;
      hi = front_i.ix1;
    end
    if (bx_pos) begin
      x_ok = !((hi < front_i.ix3) || (front_i.ix2 < lo));
    end else begin
      x_ok = !((hi < front_i.ix2) || (front_i.ix3 < lo));
    end

    if (front_i.ay[DiffW-1]) begin
      lo = front_i.iy1;
      hi = front_i.iy0;
    end else begin
      lo = front_i.iy0;
      hi = front_i.iy1;
    end
    if (by_pos) begin
      y_ok = !((hi < front_i.iy3) || (front_i.iy2 < lo));
    end else begin
      y_ok = !((hi < front_i.iy2) || (front_i.iy3 < lo));
    end

    box_ok_d = x_ok && y_ok;
  end

  always_ff @(posedge clk_i) begin
    box_ok3_q <= box_ok_d;
    p_bycx_q  <= ProdW'(front_i.by) * ProdW'(front_i.cx);
    p_bxcy_q  <= ProdW'(front_i.bx) * ProdW'(front_i.cy);
    p_aybx_q  <= ProdW'(front_i.ay) * ProdW'(front_i.bx);
    p_axby_q  <= ProdW'(front_i.ax) * ProdW'(front_i.by);
    p_axcy_q  <= ProdW'(front_i.ax) * ProdW'(front_i.cy);
    p_aycx_q  <= ProdW'(front_i.ay) * ProdW'(front_i.cx);
  end

  // Stage 4: alpha and beta numerators and the shared denominator.
  assign d_d = NumW'(p_bycx_q) - NumW'(p_bxcy_q);
  assign f_d = NumW'(p_aybx_q) - NumW'(p_axby_q);
  assign e_d = NumW'(p_axcy_q) - NumW'(p_aycx_q);

  always_ff @(posedge clk_i) begin
    box_ok4_q <= box_ok3_q;
    d_q       <= d_d;
    e_q       <= e_d;
    f_q       <= f_d;
  end

  // Stage 5: each numerator must lie between zero and the denominator,
  // on whichever side the denominator's sign puts it. A zero denominator
  // passes only when both numerators are zero, which is the collinear case.
  always_comb begin
    logic f_pos, d_ok, e_ok;
    f_pos = !f_q[NumW-1] && (f_q != '0);
    if (f_pos) begin
      d_ok = !d_q[NumW-1] && (d_q <= f_q);
      e_ok = !e_q[NumW-1] && (e_q <= f_q);
    end else begin
      d_ok = (d_q[NumW-1] || (d_q == '0)) && (d_q >= f_q);
      e_ok = (e_q[NumW-1] || (e_q == '0)) && (e_q >= f_q);
    end
    hit_d = box_ok4_q && d_ok && e_ok;
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;
  assign hit_o   = hit_q;

endmodule

// ===== hw/rtl/segint_pkg_unused_guard.sv =====
module segint_hold_check (
  input  logic clk_i,
  input  logic rst_ni,
  output logic busy_o
);

  // The pipeline never refuses a beat; busy only covers the reset interval.
  logic out_of_reset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_of_reset_q <= 1'b0;
    end else begin
      out_of_reset_q <= 1'b1;
    end
  end

  assign busy_o = !out_of_reset_q;

endmodule
